>>> rtl/pal_pkg.sv
// Shared types, constants and codes for the positional array list.
package pal_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 9;
    localparam int ST_W     = 2;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_LOCATE = 3'd3,
        OP_GET    = 3'd4
    } pal_op_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } pal_status_t;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] element_value;
    } pal_req_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         list_length;
    } pal_rsp_t;

    // Handshake between the sequencer and the result register
    typedef struct packed {
        logic     valid;
        pal_rsp_t rsp;
    } pal_res_t;

endpackage

>>> rtl/positional_array_list_top.sv
// Top level of the positional array list: request intake, sequencer, store and result register.
//
// Ordered list of up to 256 signed 32-bit values with 1-based positions. Each
// request (clear, insert, delete, locate, get) returns exactly one result with
// a status and the length after the request. One request is handled at a time;
// s_ready is high only while the sequencer is idle. Clear, rejected requests,
// unused opcodes and locate on an empty list go straight to the result;
// an append writes the value first. Insert and delete shift the entries
// from the position onward, locate scans the whole list and get reads one entry.
// The time taken is set by the element store's single read port, which the
// sequencer steps through one entry per cycle. A finished result sits in the
// output register while the next request is accepted.
module positional_array_list_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pal_pkg::pal_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pal_pkg::pal_rsp_t m_data
);

    pal_pkg::pal_res_t              res;
    logic                           ctrl_idle;
    logic                           res_take;
    logic                           ram_we, ram_re;
    logic [pal_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [pal_pkg::DATA_W-1:0]     ram_wdata, ram_rdata;

    logic                           m_valid_reg, m_valid_next;
    pal_pkg::pal_rsp_t              m_data_reg;

    assign s_ready  = ctrl_idle;
    assign res_take = res.valid && (!m_valid_reg || m_ready);

    pal_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .req       (s_data),
        .idle      (ctrl_idle),
        .res       (res),
        .res_take  (res_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pal_ram #(
        .WIDTH (pal_pkg::DATA_W),
        .DEPTH (pal_pkg::CAPACITY)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (!m_valid_reg || m_ready) begin
            m_valid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_data_reg <= res.rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/pal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pal_ctrl.sv
// Request sequencer: walks the element store one entry per cycle for shift and search.
module pal_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  pal_pkg::pal_req_t            req,
    output logic                         idle,
    output pal_pkg::pal_res_t            res,
    input  logic                         res_take,
    output logic                         ram_we,
    output logic [pal_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [pal_pkg::DATA_W-1:0]   ram_wdata,
    output logic                         ram_re,
    output logic [pal_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic [pal_pkg::DATA_W-1:0]   ram_rdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRVAL = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [pal_pkg::OP_W-1:0]         op_reg, op_next;
    logic [pal_pkg::ADDR_W-1:0]       idx_reg, idx_next;
    logic [pal_pkg::DATA_W-1:0]       val_reg, val_next;
    logic [pal_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [pal_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic [pal_pkg::ADDR_W-1:0]       end_reg, end_next;
    logic [pal_pkg::ADDR_W-1:0]       src_reg, src_next;
    logic                             dv_reg, dv_next;
    logic [pal_pkg::ST_W-1:0]         status_reg, status_next;
    logic [pal_pkg::DATA_W-1:0]       rd_reg, rd_next;
    logic [pal_pkg::POS_W-1:0]        found_reg, found_next;

    logic [pal_pkg::CMP_W-1:0]        pos_w, cnt_w, pos_m1, cnt_m1;
    logic                             is_full, is_empty, ins_bad, acc_bad;

    assign pos_w    = pal_pkg::CMP_W'(req.position);
    assign cnt_w    = pal_pkg::CMP_W'(count_reg);
    assign pos_m1   = pos_w - pal_pkg::CMP_W'(1);
    assign cnt_m1   = cnt_w - pal_pkg::CMP_W'(1);
    assign is_full  = (cnt_w >= pal_pkg::CMP_W'(pal_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);
    assign ins_bad  = (req.position == '0) || (pos_w > cnt_w + pal_pkg::CMP_W'(1));
    assign acc_bad  = (req.position == '0) || (pos_w > cnt_w);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        src_next    = src_reg;
        dv_next     = 1'b0;
        status_next = status_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = src_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = addr_reg;

        // Read data from the previous scan cycle lands here
        if (dv_reg) begin
            case (op_reg)
                pal_pkg::OP_INSERT: begin
                    ram_we    = 1'b1;
                    ram_waddr = src_reg + pal_pkg::ADDR_W'(1);
                end
                pal_pkg::OP_DELETE: begin
                    if (src_reg == idx_reg) begin
                        rd_next = ram_rdata;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = src_reg - pal_pkg::ADDR_W'(1);
                    end
                end
                pal_pkg::OP_LOCATE: begin
                    if (found_reg == '0 && ram_rdata == val_reg) begin
                        found_next = pal_pkg::POS_W'(src_reg) + pal_pkg::POS_W'(1);
                    end
                end
                pal_pkg::OP_GET: begin
                    rd_next = ram_rdata;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next     = req.opcode;
                    idx_next    = pos_m1[pal_pkg::ADDR_W-1:0];
                    val_next    = req.element_value;
                    status_next = pal_pkg::STAT_OK;
                    rd_next     = '0;
                    found_next  = '0;
                    state_next  = S_DONE;
                    case (req.opcode)
                        pal_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        pal_pkg::OP_INSERT: begin
                            if (is_full) begin
                                status_next = pal_pkg::STAT_FULL;
                            end else if (ins_bad) begin
                                status_next = pal_pkg::STAT_RANGE;
                            end else if (pos_m1 == cnt_w) begin
                                state_next = S_WRVAL;   // append, nothing to move
                            end else begin
                                addr_next  = cnt_m1[pal_pkg::ADDR_W-1:0];
                                end_next   = pos_m1[pal_pkg::ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (is_empty) begin
                                status_next = pal_pkg::STAT_EMPTY;
                            end else if (acc_bad) begin
                                status_next = pal_pkg::STAT_RANGE;
                            end else begin
                                addr_next  = pos_m1[pal_pkg::ADDR_W-1:0];
                                end_next   = cnt_m1[pal_pkg::ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        pal_pkg::OP_LOCATE: begin
                            if (!is_empty) begin
                                addr_next  = '0;
                                end_next   = cnt_m1[pal_pkg::ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        pal_pkg::OP_GET: begin
                            if (is_empty) begin
                                status_next = pal_pkg::STAT_EMPTY;
                            end else if (acc_bad) begin
                                status_next = pal_pkg::STAT_RANGE;
                            end else begin
                                addr_next  = pos_m1[pal_pkg::ADDR_W-1:0];
                                end_next   = pos_m1[pal_pkg::ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_re   = 1'b1;
                dv_next  = 1'b1;
                src_next = addr_reg;
                if (addr_reg == end_reg) begin
                    state_next = S_DRAIN;
                end else if (op_reg == pal_pkg::OP_INSERT) begin
                    addr_next = addr_reg - pal_pkg::ADDR_W'(1);   // shift up walks downward
                end else begin
                    addr_next = addr_reg + pal_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (op_reg == pal_pkg::OP_INSERT) begin
                    state_next = S_WRVAL;
                end else begin
                    if (op_reg == pal_pkg::OP_DELETE) begin
                        count_next = count_reg - pal_pkg::CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_WRVAL: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + pal_pkg::CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        addr_reg   <= addr_next;
        end_reg    <= end_next;
        src_reg    <= src_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
    end

    assign idle                   = (state_reg == S_IDLE);
    assign res.valid              = (state_reg == S_DONE);
    assign res.rsp.status         = status_reg;
    assign res.rsp.read_value     = rd_reg;
    assign res.rsp.found_position = found_reg;
    assign res.rsp.list_length    = pal_pkg::POS_W'(count_reg);

endmodule

>>> rtl/pal_check.sv
// Port-level checker for the positional array list, bound to the top level.
module pal_check (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pal_pkg::pal_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pal_pkg::pal_rsp_t m_data
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight: intake closes after an accept
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.list_length <= pal_pkg::POS_W'(pal_pkg::CAPACITY))
        else $error("length above capacity");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != pal_pkg::STAT_OK |->
            m_data.read_value == '0 && m_data.found_position == '0)
        else $error("failed request carries data");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.found_position <= m_data.list_length)
        else $error("found position beyond length");

endmodule

bind positional_array_list_top pal_check u_pal_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
